>>> rtl/core/led_flame_frame_engine_assert.svh
// Assertion helpers shared by the flame engine RTL.
// Every check is sampled on clk and switched off while rst_n is low.
`ifndef LED_FLAME_FRAME_ENGINE_ASSERT_SVH
`define LED_FLAME_FRAME_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define LFF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define LFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/lff_pkg.sv
package lff_pkg;

  // Strip length, valid from 8 to 64 cells.
  localparam int NUM_CELLS = 60;

  localparam int HEAT_W = 8;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 6;
  localparam int SPAN_W = 9;
  localparam int RND_W  = 16;
  localparam int SEED_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CELLS - 1);

  // cooling*10/NUM_CELLS by reciprocal; exact for all 12-bit products
  localparam int COOL_SHIFT = 20;
  localparam logic [17:0] COOL_RECIP = 18'((2**COOL_SHIFT + NUM_CELLS - 1) / NUM_CELLS);

  // Draw ranges
  localparam logic [SPAN_W-1:0] ROLL_SPAN  = SPAN_W'(255);
  localparam logic [SPAN_W-1:0] POS_SPAN   = SPAN_W'(7);
  localparam logic [SPAN_W-1:0] SPARK_SPAN = SPAN_W'(95);
  localparam logic [HEAT_W-1:0] SPARK_BASE = 8'd160;

  localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COOLING  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARKING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 3'd3;

  typedef struct packed {
    logic              load;
    logic              advance;
    logic [SEED_W-1:0] seed;
  } prng_ctl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // (h*191+127)/255; 191h as shifts, /255 as multiply by 0x8081 >> 23
  function automatic logic [7:0] heat_level(input logic [HEAT_W-1:0] h);
    logic [15:0] x;
    logic [31:0] p;
    begin
      x = {h, 8'b0} - {2'b0, h, 6'b0} - {8'b0, h} + 16'd127;
      p = x * 16'h8081;
      heat_level = p[30:23];
    end
  endfunction

  function automatic rgb_t heat_color(input logic [HEAT_W-1:0] h);
    logic [7:0] level;
    logic [7:0] ramp;
    rgb_t c;
    begin
      level = heat_level(h);
      ramp  = {level[5:0], 2'b00};
      if (level > 8'h80) begin
        c = '{red: 8'hFF, green: 8'hFF, blue: ramp};
      end else if (level > 8'h40) begin
        c = '{red: 8'hFF, green: ramp, blue: 8'h00};
      end else begin
        c = '{red: ramp, green: 8'h00, blue: 8'h00};
      end
      heat_color = c;
    end
  endfunction

  // floor(v/3) for v up to 765
  function automatic logic [HEAT_W-1:0] div3(input logic [9:0] v);
    logic [20:0] p;
    begin
      p = v * 11'd683;
      div3 = p[18:11];
    end
  endfunction

endpackage

>>> rtl/core/lff_tick_if.sv
interface lff_tick_if;
  logic valid;
  logic ready;
  logic frame_tick;

  modport source (output valid, output frame_tick, input ready);
  modport sink   (input valid, input frame_tick, output ready);
endinterface

>>> rtl/core/lff_pixel_if.sv
interface lff_pixel_if;
  import lff_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [7:0]       red;
  logic [7:0]       green;
  logic [7:0]       blue;
  logic             last_pixel;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input last_pixel, output ready);
endinterface

>>> rtl/core/led_flame_frame_engine.sv
// Channel   Port       Dir  Payload
// -------   ---------  ---  ---------------------------------------------
// tick      in_tick    in   frame_tick
// pixel     out_pixel  out  pixel_index, red, green, blue, last_pixel
// config    cfg_*      in   cfg_we, cfg_index, cfg_wdata (write only)
//
// A frame is set by the three full turns of the heat ring: cool, diffuse and
// emit each move one cell past the ring head per cycle. A spark adds the POS
// and HEAT draws between the cool and diffuse turns.
// Stalls on out_pixel hold the ring during the emit turn and add cycles.
// in_tick is ready only between frames; a tick of 0 is taken and dropped.
// rst_n (synchronous) zeroes all heat cells and loads seed 1 into the generator.
`include "led_flame_frame_engine_assert.svh"

module led_flame_frame_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  lff_tick_if.sink                       in_tick,
  lff_pixel_if.source                    out_pixel,
  input  logic                           cfg_we,
  input  logic [lff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lff_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lff_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SPAN = 3'd1;
  localparam logic [2:0] ST_COOL = 3'd2;
  localparam logic [2:0] ST_ROLL = 3'd3;
  localparam logic [2:0] ST_POS  = 3'd4;
  localparam logic [2:0] ST_HEAT = 3'd5;
  localparam logic [2:0] ST_DIFF = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Configuration
  logic [7:0] cooling_r, cooling_nxt;
  logic [7:0] sparking_r, sparking_nxt;
  logic       reverse_r, reverse_nxt;
  logic       seed_load;

  // Frame working registers
  logic [SPAN_W-1:0] span_r, span_nxt;
  logic              fire_r, fire_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [HEAT_W-1:0] sheat_r, sheat_nxt;
  logic [HEAT_W-1:0] p1_r, p1_nxt;
  logic [HEAT_W-1:0] p2_r, p2_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  rgb_t             out_rgb_r, out_rgb_nxt;
  logic             out_last_r, out_last_nxt;

  // Heat ring
  logic [HEAT_W-1:0] heat_q [NUM_CELLS];
  logic [HEAT_W-1:0] head;
  logic [HEAT_W-1:0] tail_in;
  logic              rotate;

  // Shared draw unit
  prng_ctl_t         prng_ctl;
  logic [RND_W-1:0]  rnd;
  logic [SPAN_W-1:0] draw_span;
  logic [24:0]       draw_prod;
  logic [SPAN_W-1:0] draw;

  logic              emit_step;
  logic [11:0]       cool10;
  logic [29:0]       span_prod;
  logic [9:0]        diff_sum;
  logic [HEAT_W-1:0] diff_val;
  logic [HEAT_W:0]   spark_sum;

  assign head = heat_q[0];

  // Ring: each cell takes its upper neighbor; the head re-enters at the tail
  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    logic [HEAT_W-1:0] d;
    if (j == NUM_CELLS - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_body
      assign d = heat_q[j+1];
    end
    lff_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (rotate),
      .d     (d),
      .q     (heat_q[j])
    );
  end

  lff_prng u_prng (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (prng_ctl),
    .rnd   (rnd)
  );

  // One multiplier scales every draw to its range
  always_comb begin
    case (state_r)
      ST_COOL: draw_span = span_r;
      ST_ROLL: draw_span = ROLL_SPAN;
      ST_POS:  draw_span = POS_SPAN;
      default: draw_span = SPARK_SPAN;
    endcase
    draw_prod = rnd * draw_span;
    draw      = draw_prod[24:16];
  end

  // Cooling span: cooling*10/NUM_CELLS + 2
  always_comb begin
    cool10    = {1'b0, cooling_r, 3'b0} + {3'b0, cooling_r, 1'b0};
    span_prod = cool10 * COOL_RECIP;
  end

  // Diffusion from the two previous (pre-update) heads, then the spark
  always_comb begin
    diff_sum  = {2'b0, p1_r} + {1'b0, p2_r, 1'b0};
    diff_val  = (cnt_r >= CNT_W'(2)) ? div3(diff_sum) : head;
    spark_sum = {1'b0, diff_val} + {1'b0, sheat_r};
  end

  assign seed_load = cfg_we && (cfg_index == CFG_SEED);
  assign emit_step = !out_valid_r || out_pixel.ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    span_nxt      = span_r;
    fire_nxt      = fire_r;
    pos_nxt       = pos_r;
    sheat_nxt     = sheat_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    out_index_nxt = out_index_r;
    out_rgb_nxt   = out_rgb_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_pixel.ready;
    rotate        = 1'b0;
    tail_in       = head;
    prng_ctl      = '{load: seed_load, advance: 1'b0, seed: cfg_wdata};

    case (state_r)
      ST_IDLE: begin
        if (in_tick.valid && in_tick.frame_tick) begin
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        span_nxt  = SPAN_W'(span_prod >> COOL_SHIFT) + SPAN_W'(2);
        cnt_nxt   = '0;
        state_nxt = ST_COOL;
      end
      ST_COOL: begin
        rotate           = 1'b1;
        prng_ctl.advance = 1'b1;
        tail_in = (draw > {1'b0, head}) ? '0 : (head - draw[HEAT_W-1:0]);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROLL;
        end
      end
      ST_ROLL: begin
        prng_ctl.advance = 1'b1;
        fire_nxt  = draw < {1'b0, sparking_r};
        state_nxt = fire_nxt ? ST_POS : ST_DIFF;
      end
      ST_POS: begin
        prng_ctl.advance = 1'b1;
        pos_nxt   = draw[2:0];
        state_nxt = ST_HEAT;
      end
      ST_HEAT: begin
        prng_ctl.advance = 1'b1;
        sheat_nxt = SPARK_BASE + draw[HEAT_W-1:0];
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        rotate  = 1'b1;
        tail_in = diff_val;
        if (fire_r && (cnt_r == {3'b0, pos_r})) begin
          tail_in = spark_sum[HEAT_W] ? 8'hFF : spark_sum[HEAT_W-1:0];
        end
        p2_nxt  = p1_r;
        p1_nxt  = head;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_step) begin
          rotate        = 1'b1;
          out_valid_nxt = 1'b1;
          out_rgb_nxt   = heat_color(head);
          out_index_nxt = reverse_r ? IDX_W'(cnt_r) : IDX_W'(CNT_LAST - cnt_r);
          out_last_nxt  = cnt_r == CNT_LAST;
          cnt_nxt       = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Configuration writes; unknown indexes drop
  always_comb begin
    cooling_nxt  = cooling_r;
    sparking_nxt = sparking_r;
    reverse_nxt  = reverse_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_COOLING:  cooling_nxt  = cfg_wdata[7:0];
        CFG_SPARKING: sparking_nxt = cfg_wdata[7:0];
        CFG_REVERSE:  reverse_nxt  = cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fire_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cooling_r   <= 8'd55;
      sparking_r  <= 8'd120;
      reverse_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fire_r      <= fire_nxt;
      out_valid_r <= out_valid_nxt;
      cooling_r   <= cooling_nxt;
      sparking_r  <= sparking_nxt;
      reverse_r   <= reverse_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    span_r      <= span_nxt;
    pos_r       <= pos_nxt;
    sheat_r     <= sheat_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    out_index_r <= out_index_nxt;
    out_rgb_r   <= out_rgb_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tick.ready         = state_r == ST_IDLE;
  assign out_pixel.valid       = out_valid_r;
  assign out_pixel.pixel_index = out_index_r;
  assign out_pixel.red         = out_rgb_r.red;
  assign out_pixel.green       = out_rgb_r.green;
  assign out_pixel.blue        = out_rgb_r.blue;
  assign out_pixel.last_pixel  = out_last_r;

  `LFF_ASSERT_NEXT(a_tick_starts_frame,
    in_tick.valid && in_tick.ready && in_tick.frame_tick, state_r == ST_SPAN)
  `LFF_ASSERT_NEXT(a_stall_holds_ring,
    state_r == ST_EMIT && out_valid_r && !out_pixel.ready, $stable(heat_q[0]))
  `LFF_ASSERT_NEXT(a_last_ends_frame,
    state_r == ST_EMIT && emit_step && cnt_r == CNT_LAST,
    out_last_r && out_valid_r && state_r == ST_IDLE)
  `LFF_ASSERT_IMPLY(a_cnt_in_range,
    state_r == ST_COOL || state_r == ST_DIFF || state_r == ST_EMIT, cnt_r <= CNT_LAST)

endmodule

>>> rtl/core/lff_cell.sv
module lff_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift,
  input  logic [lff_pkg::HEAT_W-1:0] d,
  output logic [lff_pkg::HEAT_W-1:0] q
);
  import lff_pkg::*;

  logic [HEAT_W-1:0] heat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r <= '0;
    end else if (shift) begin
      heat_r <= d;
    end
  end

  assign q = heat_r;

endmodule

>>> rtl/core/lff_prng.sv
`include "led_flame_frame_engine_assert.svh"

module lff_prng (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lff_pkg::prng_ctl_t        ctl,
  output logic [lff_pkg::RND_W-1:0] rnd
);
  import lff_pkg::*;

  logic [SEED_W-1:0] state_r;
  logic [SEED_W-1:0] state_nxt;
  logic [SEED_W-1:0] x1, x2, x3;

  // xorshift 13/17/5
  always_comb begin
    x1 = state_r ^ (state_r << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
  end

  // draw uses the upper half of the advanced state
  assign rnd = x3[SEED_W-1 -: RND_W];

  always_comb begin
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = (ctl.seed == '0) ? SEED_RESET : ctl.seed;
    end else if (ctl.advance) begin
      state_nxt = x3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

  `LFF_ASSERT_NEXT(a_state_nonzero, 1'b1, state_r != '0)

endmodule
